// ===== hdl/rnp_pkg.sv =====
// Shared types and helpers for the RGB565 to 9-bit bus word packer.
// Depends on nothing; every other file of the block imports it.
package rnp_pkg;

  // Data flag carried in bit 8 of every non-padding bus word.
  localparam logic [8:0] DataFlag = 9'h100;

  // One classified pixel: up to two data words, then zero padding words.
  typedef struct packed {
    logic [8:0] w0;      // first data word
    logic [8:0] w1;      // second data word, valid when two is set
    logic       two;     // two data words instead of one
    logic [1:0] pad;     // number of NOP words after the data words
    logic       last;    // the final word of this request closes the frame
  } cmd_t;

  // Reduce a 5-bit channel to 4 bits: floor(c * 15 / 31).
  // For c >= 1 this equals (c - 1) / 2, since the difference stays below one half.
  function automatic logic [3:0] chan5_to_4(input logic [4:0] c);
    logic [4:0] dec;
    dec = c - 5'd1;
    return (c == 5'd0) ? 4'd0 : dec[4:1];
  endfunction

  // Reduce a 6-bit channel to 4 bits: floor(c * 15 / 63) = floor(5c / 21).
  // A reciprocal estimate is low by at most one, fixed by a single compare.
  function automatic logic [3:0] chan6_to_4(input logic [5:0] c);
    logic [8:0]  x;
    logic [15:0] prod;
    logic [3:0]  q0;
    logic [8:0]  r;
    x    = ({3'd0, c} << 2) + {3'd0, c};
    prod = 16'(x) * 16'd195;
    q0   = prod[15:12];
    r    = x - 9'(q0 * 5'd21);
    return (r >= 9'd21) ? q0 + 4'd1 : q0;
  endfunction

endpackage

// ===== hdl/rnp_front.sv =====
// Front part of the packer: converts pixels and classifies them into requests.
// Depends on rnp_pkg for the request type and the channel reduction helpers.
module rnp_front
  import rnp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] pixel_i,
  input  logic        frame_end_i,
  input  logic        accept_i,
  output cmd_t        cmd_o
);

  logic       second_q, second_d;
  logic [3:0] held_q, held_d;
  logic [1:0] mod4_q, mod4_d;

  logic [3:0] r4, g4, b4;
  logic [1:0] ndata;
  logic [1:0] cnt;

  // Channel reduction.
  assign r4 = chan5_to_4(pixel_i[15:11]);
  assign g4 = chan6_to_4(pixel_i[10:5]);
  assign b4 = chan5_to_4(pixel_i[4:0]);

  // Build the request and the next pairing state.
  always_comb begin
    cmd_o.last = frame_end_i;
    if (second_q) begin
      cmd_o.w0 = DataFlag | {1'b0, held_q, r4};
      cmd_o.w1 = DataFlag | {1'b0, g4, b4};
    end else begin
      cmd_o.w0 = DataFlag | {1'b0, r4, g4};
      cmd_o.w1 = DataFlag | {1'b0, b4, 4'd0};
    end
    cmd_o.two = second_q || frame_end_i;
    ndata     = cmd_o.two ? 2'd2 : 2'd1;
    cnt       = mod4_q + ndata;
    cmd_o.pad = frame_end_i ? 2'd0 - cnt : 2'd0;

    second_d = second_q;
    held_d   = held_q;
    mod4_d   = mod4_q;
    if (accept_i) begin
      if (frame_end_i) begin
        second_d = 1'b0;
        held_d   = 4'd0;
        mod4_d   = 2'd0;
      end else begin
        second_d = !second_q;
        held_d   = b4;
        mod4_d   = cnt;
      end
    end
  end

  // Pairing state and word count of the current frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
      held_q   <= 4'd0;
      mod4_q   <= 2'd0;
    end else begin
      second_q <= second_d;
      held_q   <= held_d;
      mod4_q   <= mod4_d;
    end
  end

endmodule

// ===== hdl/rnp_cmd_fifo.sv =====
// Short request queue between the front and back parts of the packer.
// Depends on rnp_pkg for the request type.
module rnp_cmd_fifo
  import rnp_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wr_data_i,
  output logic full_o,
  input  logic rd_i,
  output cmd_t rd_data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            slots_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o    = (count_q == CntW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = slots_q[rd_ptr_q];

  // Storage slots.
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      slots_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        count_q <= count_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/rnp_back.sv =====
// Back part of the packer: plays out each request word by word into an output register.
// Depends on rnp_pkg for the request type.
module rnp_back
  import rnp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic       cmd_valid_i,
  output logic       cmd_pop_o,
  input  logic       pop,
  output logic       empty,
  output logic [8:0] bus_word_o,
  output logic       word_last_o
);

  logic       out_valid_q;
  logic [8:0] word_q, word_d;
  logic       last_q, last_d;
  logic [2:0] step_q;
  logic [2:0] total;
  logic       last_step;
  logic       adv;
  logic       take;

  // Word selection for the current step of the request.
  always_comb begin
    total     = (cmd_i.two ? 3'd2 : 3'd1) + {1'b0, cmd_i.pad};
    last_step = (step_q == total - 3'd1);
    if (step_q == 3'd0) begin
      word_d = cmd_i.w0;
    end else if (step_q == 3'd1 && cmd_i.two) begin
      word_d = cmd_i.w1;
    end else begin
      word_d = 9'd0;
    end
    last_d = cmd_i.last && last_step;
  end

  // Load a new word when a request is waiting and the output register is free or being taken.
  assign adv       = !out_valid_q || pop;
  assign take      = adv && cmd_valid_i;
  assign cmd_pop_o = take && last_step;

  // Control: output valid and step within the request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= 3'd0;
    end else begin
      if (take) begin
        out_valid_q <= 1'b1;
        step_q      <= last_step ? 3'd0 : step_q + 3'd1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q <= word_d;
      last_q <= last_d;
    end
  end

  assign empty       = !out_valid_q;
  assign bus_word_o  = word_q;
  assign word_last_o = last_q;

endmodule

// ===== hdl/rgb565_to_rgb444_nine_bit_packer.sv =====
// An accepted pixel's request is written into the request queue, then its first word
// into the back part's output register. Throughput: one bus word per cycle from the
// output register while words are popped and requests are queued; a pixel yields one
// to five bus words (three per pair, plus flush and padding at frame end). The front
// takes a pixel per cycle while the request queue has room. Reset is asynchronous and
// clears the pairing state, word count, queue and output register valid bit.
module rgb565_to_rgb444_nine_bit_packer
  import rnp_pkg::*;
#(
  parameter int unsigned CMD_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] pixel_i,
  input  logic        frame_end_i,
  input  logic        push,
  output logic        full,
  output logic [8:0]  bus_word_o,
  output logic        word_last_o,
  output logic        empty,
  input  logic        pop
);

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic accept;
  logic cmd_empty;
  logic cmd_pop;

  assign accept = push && !full;

  // Front: conversion and classification.
  rnp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pixel_i    (pixel_i),
    .frame_end_i(frame_end_i),
    .accept_i   (accept),
    .cmd_o      (front_cmd)
  );

  // Request queue.
  rnp_cmd_fifo #(
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (accept),
    .wr_data_i(front_cmd),
    .full_o   (full),
    .rd_i     (cmd_pop),
    .rd_data_o(back_cmd),
    .empty_o  (cmd_empty)
  );

  // Back: word sequencing and output register.
  rnp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (back_cmd),
    .cmd_valid_i(!cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .pop        (pop),
    .empty      (empty),
    .bus_word_o (bus_word_o),
    .word_last_o(word_last_o)
  );

  // A shown word is either a data word with its flag or a NOP pad.
  a_word_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (bus_word_o[8] || bus_word_o == 9'd0))
    else $error("bus word neither data nor padding");

  // A queued request reaches the free output register in the next cycle.
  a_back_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd_empty && empty) |=> !empty)
    else $error("back part stalled with free output register");

  // The queue fills only through an accepted pixel.
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("queue became full without an accepted pixel");

endmodule
